@@ design/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared definitions of the software timer table
// field widths, operation and status codes, default sizes
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  // default table geometry
  localparam int DEF_SLOTS     = 16;
  localparam int DEF_TICK_BITS = 32;

  // beat field widths
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 4;
  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 32;
  localparam int CB_W     = 8;
  localparam int ARG_W    = 32;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE  = 3'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 2'd2;

endpackage

`default_nettype wire

@@ design/stt_if.sv @@
// ----------------------------------------------------------------------------
// stt_in_if / stt_out_if: request and result channels
// valid/ready channels carrying one request or one result per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_in_if import stt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SLOT_W-1:0]   slot;
  logic [TICK_W-1:0]   tick_now;
  logic [PERIOD_W-1:0] period;
  logic                periodic;
  logic [CB_W-1:0]     callback_id;
  logic [ARG_W-1:0]    argument;

  modport source (
    output valid, op, slot, tick_now, period, periodic, callback_id, argument,
    input  ready
  );
  modport sink (
    input  valid, op, slot, tick_now, period, periodic, callback_id, argument,
    output ready
  );
endinterface

interface stt_out_if import stt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [CB_W-1:0]     fired_callback;
  logic [ARG_W-1:0]    fired_argument;
  logic                last;

  modport source (
    output valid, status, slot_out, fired_callback, fired_argument, last,
    input  ready
  );
  modport sink (
    input  valid, status, slot_out, fired_callback, fired_argument, last,
    output ready
  );
endinterface

`default_nettype wire

@@ design/stt_ram.sv @@
// ----------------------------------------------------------------------------
// stt_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/stt_expiry.sv @@
// ----------------------------------------------------------------------------
// stt_expiry: shared expiry compare unit
// wrapping elapsed time against the slot timeout
// ----------------------------------------------------------------------------
`default_nettype none

module stt_expiry #(
  parameter int TICK_BITS = 32
) (
  input  wire logic [TICK_BITS-1:0] now,
  input  wire logic [TICK_BITS-1:0] start,
  input  wire logic [TICK_BITS-1:0] timeout,
  output      logic                 hit
);

  logic [TICK_BITS-1:0] elapsed;

  // subtraction wraps modulo the tick width
  assign elapsed = now - start;
  assign hit     = (elapsed >= timeout);

endmodule

`default_nettype wire

@@ design/software_timer_table_top.sv @@
// ----------------------------------------------------------------------------
// software_timer_table_top: table of software timer slots
// add, remove, update, restart and check over SLOTS timer slots
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one request beat (op, slot, tick_now, period, periodic,
//   callback_id, argument); out_ch carries result beats, last marks the
//   final result of a request
//   add scans the used bits one slot a cycle, then waits while out_ch stalls
//   remove, update, restart and unknown ops are done in S_SINGLE
//   check walks every slot through the shared expiry compare, a ram read
//   and a compare per slot, then S_FIN; expiries wait while out_ch stalls
//   the slot walk and the single read port of each slot ram set the rate
//   one request is in flight at a time; in_ch.ready is high only while idle
//   results sit in an output register, so a new request is taken while the
//   previous final result still waits
//   when out_ch stalls, the sequencer waits with the pending result held
//   reset frees every slot; slot contents are undefined until written
//   and are never used from a free slot
// ----------------------------------------------------------------------------
`default_nettype none

module software_timer_table_top import stt_pkg::*; #(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int TICK_BITS = DEF_TICK_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stt_in_if.sink     in_ch,
  stt_out_if.source  out_ch
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CFG_W = 1 + TICK_BITS + ARG_W;
  localparam logic [SW-1:0] IDX_LAST = SW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_SINGLE,
    S_CHK_RD,
    S_CHK_EV,
    S_FIN
  } state_t;

  // sequencer state
  state_t               state_r, state_nxt;
  logic [SW-1:0]        idx_r, idx_nxt;
  logic [SLOTS-1:0]     in_use_r, in_use_nxt;

  // latched request
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [TICK_BITS-1:0] now_r, now_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic                 periodic_r, periodic_nxt;
  logic [CB_W-1:0]      cbid_r, cbid_nxt;
  logic [ARG_W-1:0]     arg_r, arg_nxt;

  // expiry held back until the next one (or the end) decides last
  logic                 held_v_r, held_v_nxt;
  logic [SLOT_W-1:0]    held_slot_r, held_slot_nxt;
  logic [CB_W-1:0]      held_cb_r, held_cb_nxt;
  logic [ARG_W-1:0]     held_arg_r, held_arg_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [CB_W-1:0]      out_cb_r, out_cb_nxt;
  logic [ARG_W-1:0]     out_arg_r, out_arg_nxt;
  logic                 out_last_r, out_last_nxt;

  // slot memories
  logic                 start_we, cfg_we, id_we;
  logic [SW-1:0]        start_wa, cfg_wa;
  logic [TICK_BITS-1:0] start_rd;
  logic [CFG_W-1:0]     cfg_wd, cfg_rd;
  logic [CB_W-1:0]      id_rd;

  // scan datapath
  logic                 out_free;
  logic                 slot_ok;
  logic [SW-1:0]        slot_idx;
  logic                 exp_hit;
  logic                 chk_hit;
  logic                 chk_mode;
  logic [TICK_BITS-1:0] chk_timeout;
  logic [ARG_W-1:0]     chk_arg;
  logic                 chk_act;

  assign out_free = !out_valid_r || out_ch.ready;
  assign slot_ok  = (32'(slot_r) < 32'(SLOTS));
  assign slot_idx = SW'(slot_r);

  // timeout, mode and argument share one ram row
  assign cfg_wd      = {periodic_r, TICK_BITS'(period_r), arg_r};
  assign chk_mode    = cfg_rd[CFG_W-1];
  assign chk_timeout = cfg_rd[ARG_W +: TICK_BITS];
  assign chk_arg     = cfg_rd[ARG_W-1:0];

  stt_ram #(.WIDTH(TICK_BITS), .DEPTH(SLOTS)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (start_wa),
    .wdata (now_r),
    .raddr (idx_r),
    .rdata (start_rd)
  );

  stt_ram #(.WIDTH(CFG_W), .DEPTH(SLOTS)) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (cfg_wa),
    .wdata (cfg_wd),
    .raddr (idx_r),
    .rdata (cfg_rd)
  );

  stt_ram #(.WIDTH(CB_W), .DEPTH(SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (idx_r),
    .wdata (cbid_r),
    .raddr (idx_r),
    .rdata (id_rd)
  );

  // one compare unit serves every slot of a check
  stt_expiry #(.TICK_BITS(TICK_BITS)) u_expiry (
    .now     (now_r),
    .start   (start_rd),
    .timeout (chk_timeout),
    .hit     (exp_hit)
  );

  assign chk_hit = in_use_r[idx_r] && exp_hit;
  // a second expiry needs the output register to flush the held one
  assign chk_act = !(chk_hit && held_v_r && !out_free);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    in_use_nxt     = in_use_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    now_nxt        = now_r;
    period_nxt     = period_r;
    periodic_nxt   = periodic_r;
    cbid_nxt       = cbid_r;
    arg_nxt        = arg_r;
    held_v_nxt     = held_v_r;
    held_slot_nxt  = held_slot_r;
    held_cb_nxt    = held_cb_r;
    held_arg_nxt   = held_arg_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_cb_nxt     = out_cb_r;
    out_arg_nxt    = out_arg_r;
    out_last_nxt   = out_last_r;
    start_we       = 1'b0;
    start_wa       = idx_r;
    cfg_we         = 1'b0;
    cfg_wa         = idx_r;
    id_we          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_ch.op;
          slot_nxt     = in_ch.slot;
          now_nxt      = TICK_BITS'(in_ch.tick_now);
          period_nxt   = in_ch.period;
          periodic_nxt = in_ch.periodic;
          cbid_nxt     = in_ch.callback_id;
          arg_nxt      = in_ch.argument;
          idx_nxt      = '0;
          held_v_nxt   = 1'b0;
          case (in_ch.op)
            OP_ADD:   state_nxt = S_ADD_SCAN;
            OP_CHECK: state_nxt = S_CHK_RD;
            default:  state_nxt = S_SINGLE;
          endcase
        end
      end

      S_ADD_SCAN: begin
        if (!in_use_r[idx_r]) begin
          if (out_free) begin
            in_use_nxt[idx_r] = 1'b1;
            start_we          = 1'b1;
            cfg_we            = 1'b1;
            id_we             = 1'b1;
            out_valid_nxt     = 1'b1;
            out_status_nxt    = ST_DONE;
            out_slot_nxt      = SLOT_W'(idx_r);
            out_cb_nxt        = '0;
            out_arg_nxt       = '0;
            out_last_nxt      = 1'b1;
            state_nxt         = S_IDLE;
          end
        end else if (idx_r == IDX_LAST) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            out_slot_nxt   = '0;
            out_cb_nxt     = '0;
            out_arg_nxt    = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_SINGLE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_slot_nxt   = slot_r;
          out_cb_nxt     = '0;
          out_arg_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          case (op_r)
            OP_REMOVE: begin
              if (slot_ok) begin
                in_use_nxt[slot_idx] = 1'b0;
              end
            end
            OP_UPDATE: begin
              if (slot_ok && in_use_r[slot_idx]) begin
                cfg_we = 1'b1;
                cfg_wa = slot_idx;
              end
            end
            OP_RESTART: begin
              if (slot_ok) begin
                start_we = 1'b1;
                start_wa = slot_idx;
              end
            end
            default: begin
              out_slot_nxt = '0;
            end
          endcase
        end
      end

      S_CHK_RD: begin
        state_nxt = S_CHK_EV;
      end

      S_CHK_EV: begin
        if (chk_act) begin
          if (chk_hit) begin
            if (chk_mode) begin
              start_we = 1'b1;
            end else begin
              in_use_nxt[idx_r] = 1'b0;
            end
            if (held_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EXPIRED;
              out_slot_nxt   = held_slot_r;
              out_cb_nxt     = held_cb_r;
              out_arg_nxt    = held_arg_r;
              out_last_nxt   = 1'b0;
            end
            held_v_nxt    = 1'b1;
            held_slot_nxt = SLOT_W'(idx_r);
            held_cb_nxt   = id_rd;
            held_arg_nxt  = chk_arg;
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_CHK_RD;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (held_v_r) begin
            out_status_nxt = ST_EXPIRED;
            out_slot_nxt   = held_slot_r;
            out_cb_nxt     = held_cb_r;
            out_arg_nxt    = held_arg_r;
          end else begin
            out_status_nxt = ST_DONE;
            out_slot_nxt   = '0;
            out_cb_nxt     = '0;
            out_arg_nxt    = '0;
          end
          held_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    now_r        <= now_nxt;
    period_r     <= period_nxt;
    periodic_r   <= periodic_nxt;
    cbid_r       <= cbid_nxt;
    arg_r        <= arg_nxt;
    held_slot_r  <= held_slot_nxt;
    held_cb_r    <= held_cb_nxt;
    held_arg_r   <= held_arg_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_cb_r     <= out_cb_nxt;
    out_arg_r    <= out_arg_nxt;
    out_last_r   <= out_last_nxt;
  end

  // ports
  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.slot_out       = out_slot_r;
  assign out_ch.fired_callback = out_cb_r;
  assign out_ch.fired_argument = out_arg_r;
  assign out_ch.last           = out_last_r;

  // checks

  // a request beat closes the input until the sequencer returns to idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after a request beat");

  // no expiry is left held over once the sequencer is idle
  a_no_held_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !held_v_r)
    else $error("held expiry left over in idle");

  // only expiry beats may be followed by more beats of the same request
  a_not_last_is_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == ST_EXPIRED))
    else $error("non-final result that is not an expiry");

  // an expired one-shot slot is freed
  a_one_shot_freed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK_EV && chk_act && chk_hit && !chk_mode)
      |=> !in_use_r[$past(idx_r)])
    else $error("expired one-shot slot still in use");

endmodule

`default_nettype wire
